// File: src/smfl_pkg.sv
// ---------------------------------------------------------------------------
// smfl_pkg
// Types, constants and helpers shared by the substring matcher modules.
// ---------------------------------------------------------------------------
package smfl_pkg;

    localparam int BYTE_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int LEN_W     = 4;
    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIND_LAST_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD      = 2'd3;

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'd32;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } in_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic               overflow;
    } out_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]     pattern_length;
        logic                 find_last_mode;
        logic                 case_fold;
    } cfg_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c,
                                                   input logic ic);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ic && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
            r = c + CASE_OFFSET;
        return r;
    endfunction

endpackage

// File: src/substring_match_first_last_unit.sv
// ---------------------------------------------------------------------------
// substring_match_first_last_unit
// Streaming substring search with find-first / find-last and optional ASCII
// case folding. One result per text, on its end-of-text byte.
// ---------------------------------------------------------------------------
//  channel | signals                             | moves
//  --------+-------------------------------------+-------------------------
//  in      | in_valid / in_ready / in_data       | one text byte + flag
//  out     | out_valid / out_ready / out_data    | found, index, overflow
//  cfg     | cfg_valid / cfg_ready / cfg_index,  | one register write
//          | cfg_data                            |
//
//  One byte per cycle sustained; a request passes the input register, then
//  the window compare into the result register.
//  The result register frees the input side: bytes keep flowing while a
//  result waits, only an end-of-text byte stalls behind an untaken result.
//  Async active-low reset clears the search state and loads the register
//  defaults (pattern 0, length 1, find-first, case sensitive).
// ---------------------------------------------------------------------------
module substring_match_first_last_unit #(
    parameter int              MAX_PATTERN = 8,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  smfl_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output smfl_pkg::out_t                  out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smfl_pkg::CFG_W-1:0]      cfg_data
);
    import smfl_pkg::*;

    cfg_t cfg_reg;
    logic in_valid_reg;
    in_t  in_data_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    out_t res;
    logic adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes  <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.find_last_mode <= 1'b0;
            cfg_reg.case_fold      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:  cfg_reg.pattern_bytes  <= cfg_data[PATTERN_W-1:0];
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[LEN_W-1:0];
                REG_FIND_LAST_MODE: cfg_reg.find_last_mode <= cfg_data[0];
                REG_CASE_FOLD:      cfg_reg.case_fold      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // the held byte moves on unless it ends a text and the result reg is full and not taken
    assign adv = in_valid_reg
                 && (!in_data_reg.end_of_text || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

    smfl_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (adv),
        .req   (in_data_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && in_data_reg.end_of_text)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_data_reg.end_of_text)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && in_data_reg.end_of_text
                      && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked end-of-text request");

    a_single_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(adv && in_data_reg.end_of_text) |=> !out_valid)
        else $error("result delivered more than once");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.match_index == '0)
        else $error("index set without a match");

endmodule

// File: src/smfl_cmp.sv
// ---------------------------------------------------------------------------
// smfl_cmp
// Parallel window compare: folds both sides and checks the len bytes that
// end at the current byte against the pattern.
// ---------------------------------------------------------------------------
module smfl_cmp #(
    parameter int MAX_PATTERN = 8
) (
    input  logic [MAX_PATTERN-1:0][smfl_pkg::BYTE_W-1:0] cur,
    input  smfl_pkg::cfg_t                               cfg,
    input  logic [smfl_pkg::LEN_W-1:0]                   len,
    output logic                                         hit
);
    import smfl_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] cur_f;
    logic [MAX_PATTERN-1:0]             lane_ok;

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            cur_f[k] = fold_case(cur[k], cfg.case_fold);
        end
    end

    // pattern byte k lines up with the byte len-1-k steps back
    always_comb
    begin
        logic [LEN_W-1:0] sel;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            sel = len - LEN_W'(k) - LEN_W'(1);
            if (LEN_W'(k) >= len)
                lane_ok[k] = 1'b1;
            else
                lane_ok[k] = fold_case(cfg.pattern_bytes[BYTE_W*k +: BYTE_W],
                                       cfg.case_fold) == cur_f[sel[IDX_W-1:0]];
        end
    end

    assign hit = &lane_ok;

endmodule

// File: src/smfl_core.sv
// ---------------------------------------------------------------------------
// smfl_core
// Search state: byte window, position counter and match tracking. Updates
// once per processed byte and forms the result for an end-of-text byte.
// ---------------------------------------------------------------------------
module smfl_core #(
    parameter int              MAX_PATTERN = 8,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  smfl_pkg::in_t         req,
    input  smfl_pkg::cfg_t        cfg,
    output smfl_pkg::out_t        res
);
    import smfl_pkg::*;

    localparam longint unsigned TEXT_LIMIT =
        (MAX_TEXT < 64'd65536) ? MAX_TEXT : 64'd65536;
    localparam int CNT_W = $clog2(TEXT_LIMIT + 1);
    localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(TEXT_LIMIT);
    localparam logic [CNT_W-1:0] LIMIT_M1 = CNT_W'(TEXT_LIMIT - 1);

    logic [WIN_D-1:0][BYTE_W-1:0]       win_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] cur;
    logic [CNT_W-1:0]                   pos_reg, pos_next;
    logic                               seen_reg, seen_next;
    logic [INDEX_W-1:0]                 start_reg, start_next;
    logic                               ovf_reg, ovf_next;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;
    logic             over_now;
    logic             hit;
    logic             take;
    logic [CNT_W-1:0] start_c;

    always_comb
    begin
        len = cfg.pattern_length;
        if (cfg.pattern_length == '0)
            len = LEN_W'(1);
        else if (cfg.pattern_length > LEN_W'(MAX_PATTERN))
            len = LEN_W'(MAX_PATTERN);
    end

    assign len_m1 = len - LEN_W'(1);

    always_comb
    begin
        cur[0] = req.text_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            cur[k] = win_reg[k-1];
        end
    end

    smfl_cmp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cmp (
        .cur (cur),
        .cfg (cfg),
        .len (len),
        .hit (hit)
    );

    assign over_now = (pos_reg >= LIMIT);
    assign start_c  = over_now ? LIMIT_M1 : (pos_reg - CNT_W'(len_m1));
    assign take     = hit && (pos_reg >= CNT_W'(len_m1))
                      && (cfg.find_last_mode || !seen_reg);

    always_comb
    begin
        seen_next  = seen_reg | take;
        start_next = take ? INDEX_W'(start_c) : start_reg;
        ovf_next   = ovf_reg | over_now;
        pos_next   = over_now ? pos_reg : pos_reg + CNT_W'(1);
    end

    always_comb
    begin
        res.found       = seen_next;
        res.match_index = seen_next ? start_next : '0;
        res.overflow    = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (req.end_of_text)
            begin
                win_reg   <= '0;
                pos_reg   <= '0;
                seen_reg  <= 1'b0;
                start_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                win_reg[0] <= req.text_byte;
                for (int k = 1; k < WIN_D; k++)
                begin
                    win_reg[k] <= win_reg[k-1];
                end
                pos_reg   <= pos_next;
                seen_reg  <= seen_next;
                start_reg <= start_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    a_clear_after_text: assert property (@(posedge clk) disable iff (!rst_n)
        step && req.end_of_text |=> pos_reg == '0 && !seen_reg && !ovf_reg)
        else $error("search state not cleared after end of text");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LIMIT && (!ovf_reg || pos_reg == LIMIT))
        else $error("position counter beyond limit");

endmodule
